/* design/sthc_pkg.sv */
`default_nettype none
package sthc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_REGS = 6;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int NUM_STAGES = 6;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5
  } reg_index_t;

  // triangle edge codes
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

  // sign of an orientation determinant; positive is neither flag
  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

  // per-stage load enables, bit 0 is the first stage
  typedef struct packed {
    logic st_out;
    logic st_sign;
    logic st_triple;
    logic st_minor;
    logic st_prod;
    logic st_diff;
  } pipe_ctrl_t;

  typedef struct packed {
    logic       hit;
    logic       plane_coplanar;
    logic [1:0] edge_count;
    logic [1:0] edge_first;
    logic [1:0] edge_second;
    logic [1:0] edge_third;
  } result_t;

endpackage
`default_nettype wire

/* design/sthc_tri_if.sv */
`default_nettype none
interface sthc_tri_if #(
  parameter int W = sthc_pkg::COORD_WIDTH_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] corner_a_x;
  logic [W-1:0] corner_a_y;
  logic [W-1:0] corner_a_z;
  logic [W-1:0] corner_b_x;
  logic [W-1:0] corner_b_y;
  logic [W-1:0] corner_b_z;
  logic [W-1:0] corner_c_x;
  logic [W-1:0] corner_c_y;
  logic [W-1:0] corner_c_z;

  modport source (
    output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
           corner_b_z, corner_c_x, corner_c_y, corner_c_z,
    input  ready
  );
  modport sink (
    input  valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
           corner_b_z, corner_c_x, corner_c_y, corner_c_z,
    output ready
  );
endinterface
`default_nettype wire

/* design/sthc_res_if.sv */
`default_nettype none
interface sthc_res_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic       plane_coplanar;
  logic [1:0] edge_count;
  logic [1:0] edge_first;
  logic [1:0] edge_second;
  logic [1:0] edge_third;

  modport source (
    output valid, hit, plane_coplanar, edge_count, edge_first, edge_second, edge_third,
    input  ready
  );
  modport sink (
    input  valid, hit, plane_coplanar, edge_count, edge_first, edge_second, edge_third,
    output ready
  );
endinterface
`default_nettype wire

/* design/sthc_pipe_ctrl.sv */
`default_nettype none
module sthc_pipe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sthc_pkg::pipe_ctrl_t     ctrl
);

  localparam int N = sthc_pkg::NUM_STAGES;

  logic [N-1:0] valid;
  logic [N-1:0] load;
  logic [N-1:0] valid_next;

  // a stage takes new data when empty or when its content moves on
  always_comb begin
    load[N-1] = ~valid[N-1] | out_ready;
    for (int k = N-2; k >= 0; k--) begin
      load[k] = ~valid[k] | load[k+1];
    end
    valid_next[0] = load[0] ? in_valid : valid[0];
    for (int k = 1; k < N; k++) begin
      valid_next[k] = load[k] ? valid[k-1] : valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign ctrl      = sthc_pkg::pipe_ctrl_t'(load);
  assign in_ready  = load[0];
  assign out_valid = valid[N-1];

endmodule
`default_nettype wire

/* design/sthc_orient.sv */
`default_nettype none
// Sign of det[x-w ; y-w ; z-w], five register stages.
module sthc_orient #(
  parameter int W = sthc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire sthc_pkg::pipe_ctrl_t ctrl,
  input  wire logic [W-1:0]         w [3],
  input  wire logic [W-1:0]         x [3],
  input  wire logic [W-1:0]         y [3],
  input  wire logic [W-1:0]         z [3],
  output sthc_pkg::sign_t           sgn
);

  localparam int DW = W + 1;        // coordinate difference
  localparam int PW = 2 * DW;       // 2x2 product
  localparam int MW = PW + 1;       // 2x2 minor
  localparam int TW = DW + MW;      // triple product
  localparam int SW = TW + 2;       // determinant

  logic signed [DW-1:0] u1 [3];
  logic signed [DW-1:0] v1 [3];
  logic signed [DW-1:0] t1 [3];
  logic signed [DW-1:0] u2 [3];
  logic signed [PW-1:0] pr [6];
  logic signed [DW-1:0] u3 [3];
  logic signed [MW-1:0] m3 [3];
  logic signed [TW-1:0] d4 [3];
  logic signed [SW-1:0] det;

  always_ff @(posedge clk) begin
    if (ctrl.st_diff) begin
      for (int i = 0; i < 3; i++) begin
        u1[i] <= signed'({x[i][W-1], x[i]}) - signed'({w[i][W-1], w[i]});
        v1[i] <= signed'({y[i][W-1], y[i]}) - signed'({w[i][W-1], w[i]});
        t1[i] <= signed'({z[i][W-1], z[i]}) - signed'({w[i][W-1], w[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.st_prod) begin
      pr[0] <= PW'(v1[1]) * PW'(t1[2]);
      pr[1] <= PW'(v1[2]) * PW'(t1[1]);
      pr[2] <= PW'(v1[0]) * PW'(t1[2]);
      pr[3] <= PW'(v1[2]) * PW'(t1[0]);
      pr[4] <= PW'(v1[0]) * PW'(t1[1]);
      pr[5] <= PW'(v1[1]) * PW'(t1[0]);
      u2    <= u1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.st_minor) begin
      m3[0] <= MW'(pr[0]) - MW'(pr[1]);
      m3[1] <= MW'(pr[2]) - MW'(pr[3]);
      m3[2] <= MW'(pr[4]) - MW'(pr[5]);
      u3    <= u2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.st_triple) begin
      for (int i = 0; i < 3; i++) begin
        d4[i] <= TW'(u3[i]) * TW'(m3[i]);
      end
    end
  end

  assign det = SW'(d4[0]) - SW'(d4[1]) + SW'(d4[2]);

  always_ff @(posedge clk) begin
    if (ctrl.st_sign) begin
      sgn.neg  <= det[SW-1];
      sgn.zero <= (det == '0);
    end
  end

endmodule
`default_nettype wire

/* design/sthc_classify.sv */
`default_nettype none
module sthc_classify (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire sthc_pkg::sign_t  sp,
  input  wire sthc_pkg::sign_t  sq,
  input  wire sthc_pkg::sign_t  s_ab,
  input  wire sthc_pkg::sign_t  s_bc,
  input  wire sthc_pkg::sign_t  s_ca,
  output sthc_pkg::result_t     res
);

  logic              sp_pos;
  logic              swap;
  logic              same_side;
  logic [2:0]        zr;
  logic [2:0]        pos;
  logic [2:0]        eff_pos;
  sthc_pkg::result_t res_next;

  // edge signs come from (p,q); reversing the segment negates them
  always_comb begin
    sp_pos    = ~sp.neg & ~sp.zero;
    swap      = ~(sp_pos | (sp.zero & sq.neg));
    same_side = ~sp.zero & (sp.neg == sq.neg) & ~sq.zero;
    zr        = {s_ca.zero, s_bc.zero, s_ab.zero};
    pos       = {~s_ca.neg & ~s_ca.zero, ~s_bc.neg & ~s_bc.zero, ~s_ab.neg & ~s_ab.zero};
    eff_pos   = swap ? {s_ca.neg, s_bc.neg, s_ab.neg} : pos;

    res_next = '0;
    if (sp.zero && sq.zero) begin
      res_next.hit            = 1'b1;
      res_next.plane_coplanar = 1'b1;
      res_next.edge_count     = 2'd3;
      res_next.edge_first     = sthc_pkg::EDGE_AB;
      res_next.edge_second    = sthc_pkg::EDGE_BC;
      res_next.edge_third     = sthc_pkg::EDGE_CA;
    end else if (!same_side && eff_pos == 3'b000) begin
      res_next.hit        = 1'b1;
      res_next.edge_count = 2'({1'b0, zr[0]} + {1'b0, zr[1]} + {1'b0, zr[2]});
      case (zr)
        3'b001: res_next.edge_first = sthc_pkg::EDGE_AB;
        3'b010: res_next.edge_first = sthc_pkg::EDGE_BC;
        3'b100: res_next.edge_first = sthc_pkg::EDGE_CA;
        3'b011: begin
          res_next.edge_first  = sthc_pkg::EDGE_AB;
          res_next.edge_second = sthc_pkg::EDGE_BC;
        end
        3'b101: begin
          res_next.edge_first  = sthc_pkg::EDGE_AB;
          res_next.edge_second = sthc_pkg::EDGE_CA;
        end
        3'b110: begin
          res_next.edge_first  = sthc_pkg::EDGE_BC;
          res_next.edge_second = sthc_pkg::EDGE_CA;
        end
        3'b111: begin
          res_next.edge_first  = sthc_pkg::EDGE_AB;
          res_next.edge_second = sthc_pkg::EDGE_BC;
          res_next.edge_third  = sthc_pkg::EDGE_CA;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

/* design/segment_triangle_hit_classifier.sv */
// Throughput: one triangle per cycle while the result side is ready; six
// register stages (differences, 2x2 products, minors, triple products,
// determinant sign, classification) each hold their own valid bit, so
// bubbles fill while the output stalls.
// Reset clears all valid bits and sets the segment end points to 0.
`default_nettype none
module segment_triangle_hit_classifier #(
  parameter int COORD_WIDTH = sthc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [sthc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [COORD_WIDTH-1:0]              cfg_data,
  sthc_tri_if.sink                                 triangle,
  sthc_res_if.source                               result
);

  localparam int W = COORD_WIDTH;

  logic [W-1:0] p [3];
  logic [W-1:0] q [3];
  logic [W-1:0] a [3];
  logic [W-1:0] b [3];
  logic [W-1:0] c [3];

  sthc_pkg::pipe_ctrl_t ctrl;
  sthc_pkg::sign_t      sp;
  sthc_pkg::sign_t      sq;
  sthc_pkg::sign_t      s_ab;
  sthc_pkg::sign_t      s_bc;
  sthc_pkg::sign_t      s_ca;
  sthc_pkg::result_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        p[i] <= '0;
        q[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        sthc_pkg::REG_START_X: p[0] <= cfg_data;
        sthc_pkg::REG_START_Y: p[1] <= cfg_data;
        sthc_pkg::REG_START_Z: p[2] <= cfg_data;
        sthc_pkg::REG_END_X:   q[0] <= cfg_data;
        sthc_pkg::REG_END_Y:   q[1] <= cfg_data;
        sthc_pkg::REG_END_Z:   q[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign a[0] = triangle.corner_a_x;
  assign a[1] = triangle.corner_a_y;
  assign a[2] = triangle.corner_a_z;
  assign b[0] = triangle.corner_b_x;
  assign b[1] = triangle.corner_b_y;
  assign b[2] = triangle.corner_b_z;
  assign c[0] = triangle.corner_c_x;
  assign c[1] = triangle.corner_c_y;
  assign c[2] = triangle.corner_c_z;

  sthc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (triangle.valid),
    .in_ready  (triangle.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ctrl      (ctrl)
  );

  // plane side of each endpoint
  sthc_orient #(.W(W)) u_orient_p (
    .clk(clk), .ctrl(ctrl), .w(a), .x(b), .y(c), .z(p), .sgn(sp)
  );
  sthc_orient #(.W(W)) u_orient_q (
    .clk(clk), .ctrl(ctrl), .w(a), .x(b), .y(c), .z(q), .sgn(sq)
  );

  // segment against each edge, always taken in p-to-q order
  sthc_orient #(.W(W)) u_orient_ab (
    .clk(clk), .ctrl(ctrl), .w(p), .x(q), .y(a), .z(b), .sgn(s_ab)
  );
  sthc_orient #(.W(W)) u_orient_bc (
    .clk(clk), .ctrl(ctrl), .w(p), .x(q), .y(b), .z(c), .sgn(s_bc)
  );
  sthc_orient #(.W(W)) u_orient_ca (
    .clk(clk), .ctrl(ctrl), .w(p), .x(q), .y(c), .z(a), .sgn(s_ca)
  );

  sthc_classify u_classify (
    .clk  (clk),
    .load (ctrl.st_out),
    .sp   (sp),
    .sq   (sq),
    .s_ab (s_ab),
    .s_bc (s_bc),
    .s_ca (s_ca),
    .res  (res)
  );

  assign result.hit            = res.hit;
  assign result.plane_coplanar = res.plane_coplanar;
  assign result.edge_count     = res.edge_count;
  assign result.edge_first     = res.edge_first;
  assign result.edge_second    = res.edge_second;
  assign result.edge_third     = res.edge_third;

endmodule
`default_nettype wire

/* design/sthc_checker.sv */
`default_nettype none
module sthc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       hit,
  input wire logic       plane_coplanar,
  input wire logic [1:0] edge_count,
  input wire logic [1:0] edge_first,
  input wire logic [1:0] edge_second,
  input wire logic [1:0] edge_third
);

  // pending result is not dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> !plane_coplanar && edge_count == 2'd0 &&
      edge_first == 2'd0 && edge_second == 2'd0 && edge_third == 2'd0)
    else $error("miss with nonzero fields");

  a_coplanar: assert property (@(posedge clk) disable iff (rst)
    out_valid && plane_coplanar |-> hit && edge_count == 2'd3 &&
      edge_first == 2'd0 && edge_second == 2'd1 && edge_third == 2'd2)
    else $error("in-plane segment reported wrongly");

  a_slots: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit && edge_count != 2'd3 |-> edge_third == 2'd0)
    else $error("unused edge slot not zero");

endmodule

bind segment_triangle_hit_classifier sthc_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .hit            (result.hit),
  .plane_coplanar (result.plane_coplanar),
  .edge_count     (result.edge_count),
  .edge_first     (result.edge_first),
  .edge_second    (result.edge_second),
  .edge_third     (result.edge_third)
);
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import sthc_pkg::*;

  localparam int W = COORD_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int RANDOM_PHASES = 6;
  // indexes past the last register; writes there must be dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
  } point_t;

  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
  } triangle_t;

  // Expected hit classification per accepted triangle, in request order.
  class hit_scoreboard;
    point_t seg_start;
    point_t seg_end;
    result_t pending[$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_miss;
    int unsigned n_interior;
    int unsigned n_edge;
    int unsigned n_vertex;
    int unsigned n_in_plane;

    function new();
      seg_start = '0;
      seg_end = '0;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [W-1:0] val);
      case (idx)
        REG_START_X: seg_start.x = val;
        REG_START_Y: seg_start.y = val;
        REG_START_Z: seg_start.z = val;
        REG_END_X:   seg_end.x = val;
        REG_END_Y:   seg_end.y = val;
        REG_END_Z:   seg_end.z = val;
        default: ;
      endcase
    endfunction

    // sign of det[x-w ; y-w ; z-w]; 16-bit inputs stay well inside 64 bits
    function int orient(point_t w, point_t x, point_t y, point_t z);
      longint ux, uy, uz, vx, vy, vz, tx, ty, tz, det;
      ux = longint'($signed(x.x)) - longint'($signed(w.x));
      uy = longint'($signed(x.y)) - longint'($signed(w.y));
      uz = longint'($signed(x.z)) - longint'($signed(w.z));
      vx = longint'($signed(y.x)) - longint'($signed(w.x));
      vy = longint'($signed(y.y)) - longint'($signed(w.y));
      vz = longint'($signed(y.z)) - longint'($signed(w.z));
      tx = longint'($signed(z.x)) - longint'($signed(w.x));
      ty = longint'($signed(z.y)) - longint'($signed(w.y));
      tz = longint'($signed(z.z)) - longint'($signed(w.z));
      det = ux * (vy * tz - vz * ty) - uy * (vx * tz - vz * tx) + uz * (vx * ty - vy * tx);
      return (det > 0) ? 1 : ((det < 0) ? -1 : 0);
    endfunction

    function result_t classify(triangle_t t);
      result_t r;
      point_t u, v;
      int sp, sq, n;
      int side[3];
      logic [1:0] code[3];
      r = '0;
      code = '{EDGE_AB, EDGE_BC, EDGE_CA};
      sp = orient(t.a, t.b, t.c, seg_start);
      sq = orient(t.a, t.b, t.c, seg_end);
      if (sp == 0 && sq == 0) begin
        r.hit = 1'b1;
        r.plane_coplanar = 1'b1;
        r.edge_count = 2'd3;
        r.edge_first = EDGE_AB;
        r.edge_second = EDGE_BC;
        r.edge_third = EDGE_CA;
        return r;
      end
      if (sp != 0 && sp == sq)
        return r;
      // orient the segment from the upper side; p on the plane with q below keeps (p,q)
      if (sp > 0 || (sp == 0 && sq < 0)) begin
        u = seg_start;
        v = seg_end;
      end else begin
        u = seg_end;
        v = seg_start;
      end
      side[0] = orient(u, v, t.a, t.b);
      side[1] = orient(u, v, t.b, t.c);
      side[2] = orient(u, v, t.c, t.a);
      n = 0;
      r.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (side[i] > 0)
          return '0;
        if (side[i] == 0) begin
          case (n)
            0: r.edge_first = code[i];
            1: r.edge_second = code[i];
            default: r.edge_third = code[i];
          endcase
          n++;
        end
      end
      r.edge_count = n[1:0];
      return r;
    endfunction

    function void note_triangle(triangle_t t);
      result_t r;
      r = classify(t);
      if (!r.hit)
        n_miss++;
      else if (r.plane_coplanar)
        n_in_plane++;
      else if (r.edge_count == 2'd0)
        n_interior++;
      else if (r.edge_count == 2'd1)
        n_edge++;
      else
        n_vertex++;
      pending.insert(pending.size(), r);
    endfunction

    function void match_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("result with no triangle outstanding: hit=%0b", got.hit);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      match_field("hit", 2'(want.hit), 2'(got.hit));
      match_field("plane_coplanar", 2'(want.plane_coplanar), 2'(got.plane_coplanar));
      match_field("edge_count", want.edge_count, got.edge_count);
      match_field("edge_first", want.edge_first, got.edge_first);
      match_field("edge_second", want.edge_second, got.edge_second);
      match_field("edge_third", want.edge_third, got.edge_third);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [W-1:0] cfg_data;

  sthc_tri_if #(.W(W)) tri_bus ();
  sthc_res_if res_bus ();

  segment_triangle_hit_classifier #(.COORD_WIDTH(W)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .triangle(tri_bus),
    .result(res_bus)
  );

  hit_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned n_segments = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check on each handshake, then pick next cycle's ready
  initial begin
    result_t got;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_bus.valid && res_bus.ready) begin
        got.hit = res_bus.hit;
        got.plane_coplanar = res_bus.plane_coplanar;
        got.edge_count = res_bus.edge_count;
        got.edge_first = res_bus.edge_first;
        got.edge_second = res_bus.edge_second;
        got.edge_third = res_bus.edge_third;
        sb.check_result(got);
      end
      res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic point_t mk_point(int x, int y, int z);
    point_t p;
    p.x = W'(x);
    p.y = W'(y);
    p.z = W'(z);
    return p;
  endfunction

  function automatic triangle_t mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                       int cx, int cy, int cz);
    triangle_t t;
    t.a = mk_point(ax, ay, az);
    t.b = mk_point(bx, by, bz);
    t.c = mk_point(cx, cy, cz);
    return t;
  endfunction

  function automatic point_t rand_point(int lim);
    return mk_point(int'($urandom_range(0, 2 * lim)) - lim,
                    int'($urandom_range(0, 2 * lim)) - lim,
                    int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic point_t jitter(point_t b, int spread);
    return mk_point(int'($signed(b.x)) + int'($urandom_range(0, 2 * spread)) - spread,
                    int'($signed(b.y)) + int'($urandom_range(0, 2 * spread)) - spread,
                    int'($signed(b.z)) + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic point_t extreme_point();
    return mk_point($urandom_range(0, 1) ? 32767 : -32768,
                    $urandom_range(0, 1) ? 32767 : -32768,
                    $urandom_range(0, 1) ? 32767 : -32768);
  endfunction

  // corners drawn around the segment so hits, edge and vertex cases come up often
  function automatic point_t pick_corner(point_t p, point_t q, int spread);
    point_t mid;
    mid = mk_point((int'($signed(p.x)) + int'($signed(q.x))) / 2,
                   (int'($signed(p.y)) + int'($signed(q.y))) / 2,
                   (int'($signed(p.z)) + int'($signed(q.z))) / 2);
    case ($urandom_range(0, 7))
      0: return p;
      1: return q;
      2: return jitter(p, spread);
      3: return jitter(q, spread);
      4: return rand_point(32768);
      default: return jitter(mid, spread);
    endcase
  endfunction

  function automatic triangle_t random_triangle(point_t p, point_t q);
    triangle_t t;
    int spread;
    case ($urandom_range(0, 3))
      0: spread = 1;
      1: spread = 3;
      2: spread = 50;
      default: spread = 2000;
    endcase
    if ($urandom_range(0, 9) == 0)
      return {rand_point(32768), rand_point(32768), rand_point(32768)};
    t.a = pick_corner(p, q, spread);
    t.b = pick_corner(p, q, spread);
    t.c = pick_corner(p, q, spread);
    // occasional collapsed triangle
    if ($urandom_range(0, 11) == 0)
      t.c = $urandom_range(0, 1) ? t.a : t.b;
    return t;
  endfunction

  task automatic put_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic load_segment(point_t p, point_t q);
    put_reg(REG_START_X, p.x);
    put_reg(REG_START_Y, p.y);
    put_reg(REG_START_Z, p.z);
    put_reg(REG_END_X, q.x);
    put_reg(REG_END_Y, q.y);
    put_reg(REG_END_Z, q.z);
    put_reg(IDX_SPARE_LO, W'($urandom));
    put_reg(IDX_SPARE_HI, W'($urandom));
    cfg_we <= 1'b0;
    n_segments++;
  endtask

  task automatic send_triangle(triangle_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tri_bus.valid <= 1'b0;
      @(posedge clk);
    end
    tri_bus.valid <= 1'b1;
    tri_bus.corner_a_x <= t.a.x;
    tri_bus.corner_a_y <= t.a.y;
    tri_bus.corner_a_z <= t.a.z;
    tri_bus.corner_b_x <= t.b.x;
    tri_bus.corner_b_y <= t.b.y;
    tri_bus.corner_b_z <= t.b.z;
    tri_bus.corner_c_x <= t.c.x;
    tri_bus.corner_c_y <= t.c.y;
    tri_bus.corner_c_z <= t.c.z;
    @(posedge clk);
    while (!tri_bus.ready)
      @(posedge clk);
    sb.note_triangle(t);
  endtask

  // stop requests and let the pipeline empty out
  task automatic drain();
    tri_bus.valid <= 1'b0;
    while (sb.pending.size() != 0)
      @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  initial begin
    point_t p, q;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_START_X;
    cfg_data <= '0;
    tri_bus.valid <= 1'b0;
    tri_bus.corner_a_x <= '0;
    tri_bus.corner_a_y <= '0;
    tri_bus.corner_a_z <= '0;
    tri_bus.corner_b_x <= '0;
    tri_bus.corner_b_y <= '0;
    tri_bus.corner_b_z <= '0;
    tri_bus.corner_c_x <= '0;
    tri_bus.corner_c_y <= '0;
    tri_bus.corner_c_z <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // vertical segment through the origin, triangles at z = 0 unless noted
    load_segment(mk_point(0, 0, 10), mk_point(0, 0, -10));
    send_triangle(mk_tri(-10, -10, 0, 10, -10, 0, 0, 10, 0));    // interior
    send_triangle(mk_tri(-10, -10, 0, 0, 10, 0, 10, -10, 0));    // interior, other winding
    send_triangle(mk_tri(-10, 0, 0, 10, 0, 0, 0, 10, 0));        // through edge ab
    send_triangle(mk_tri(0, 0, 0, 10, 0, 0, 0, 10, 0));          // through a vertex
    send_triangle(mk_tri(5, 5, 0, 10, 5, 0, 5, 10, 0));          // crosses plane, misses
    send_triangle(mk_tri(-10, -10, 20, 10, -10, 20, 0, 10, 20)); // both below
    send_triangle(mk_tri(-10, -10, -20, 10, -10, -20, 0, 10, -20));
    send_triangle(mk_tri(0, -10, 0, 0, 10, 0, 0, 0, 10));        // segment in plane
    send_triangle(mk_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));            // collinear corners
    send_triangle(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(mk_tri(-10, -10, 10, 10, -10, 10, 0, 10, 10)); // start on plane
    send_triangle(mk_tri(-10, -10, 10, 0, 10, 10, 10, -10, 10));
    send_triangle(mk_tri(-10, -10, -10, 10, -10, -10, 0, 10, -10)); // end on plane
    send_triangle(mk_tri(50, 50, 10, 60, 50, 10, 50, 60, 10));
    send_triangle(mk_tri(-32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0));
    send_triangle(mk_tri(32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, 0));
    drain();

    load_segment(mk_point(-32768, -32768, -32768), mk_point(32767, 32767, 32767));
    send_triangle(mk_tri(-32768, 32767, 0, 32767, -32768, 0, 32767, 32767, -32768));
    send_triangle(mk_tri(32767, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767));
    send_triangle(mk_tri(-32768, -32768, -32768, 32767, -32768, 0, 0, 32767, -32768));
    send_triangle(mk_tri(-1, -1, -1, 32767, 32767, 32767, -32768, -32768, -32768));
    send_triangle(mk_tri(0, 0, 0, 32767, 0, -32768, -32768, 32767, 0));
    send_triangle(mk_tri(-1, 0, 0, 0, -1, 0, 0, 0, -1));

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      drain();
      case (k)
        0: begin p = rand_point(8); q = rand_point(8); end
        1: begin p = rand_point(32768); q = rand_point(32768); end
        2: begin p = extreme_point(); q = extreme_point(); end
        3: begin p = rand_point(6); q = p; end
        4: begin
          p = mk_point(int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20, -32768);
          q = p;
          q.z = W'(32767);
        end
        default: begin p = rand_point(100); q = rand_point(100); end
      endcase
      load_segment(p, q);
      case (k % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 75; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 75; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (k == 1 && i == ITEMS_PER_PHASE / 2)
          drain();
        send_triangle(random_triangle(p, q));
      end
    end
    drain();

    $display("Checked %0d results over %0d segment settings, four idle/stall patterns",
             sb.n_checked, n_segments);
    $display("Outcomes: %0d miss, %0d interior, %0d edge, %0d vertex, %0d in-plane",
             sb.n_miss, sb.n_interior, sb.n_edge, sb.n_vertex, sb.n_in_plane);
    if (sb.n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
design/sthc_pkg.sv
design/sthc_tri_if.sv
design/sthc_res_if.sv
design/sthc_pipe_ctrl.sv
design/sthc_orient.sv
design/sthc_classify.sv
design/segment_triangle_hit_classifier.sv
design/sthc_checker.sv
verif/testbench.sv
